[hdl/ouvg_pkg.sv]
`timescale 1ns / 1ps

package ouvg_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned TICK_W     = 13;
  localparam int unsigned HYST_W     = 6;
  localparam int unsigned DISP_W     = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // Defaults for the top-level parameters
  localparam int unsigned SAMPLES_DEF = 64;
  localparam int unsigned TICKS_DEF   = 32;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Register reset values
  localparam logic [SAMPLE_W-1:0] OVER_RST   = 10'd550;
  localparam logic [SAMPLE_W-1:0] UNDER_RST  = 10'd370;
  localparam logic [HYST_W-1:0]   HYST_RST   = 6'd10;
  localparam logic [TICK_W-1:0]   DELAY_RST  = 13'd2400;
  localparam logic [TICK_W-1:0]   BUZZER_RST = 13'd760;

  localparam logic [TICK_W-1:0] TICK_MAX = 13'h1FFF;
  localparam logic [DISP_W-1:0] DISP_MAX = 10'd999;

  // Voltage scaling a*10/22 = (5a)/11, done as (5a * ceil(2^17/11)) >> 17
  localparam int unsigned          VOLT_X_W   = 13;
  localparam int unsigned          VOLT_SHIFT = 17;
  localparam logic [VOLT_X_W:0]    VOLT_RECIP = 14'd11916;

  // Item kinds
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OVER_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNDER_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HYST      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BUZZER    = 3'd4;

  typedef enum logic [1:0] {
    PH_START   = 2'd0,
    PH_NORMAL  = 2'd1,
    PH_FAULT   = 2'd2,
    PH_RECOVER = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    FLT_NONE  = 2'd0,
    FLT_OVER  = 2'd1,
    FLT_UNDER = 2'd2
  } fault_e;

  typedef struct packed {
    logic                cmd;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic              relay_on;
    logic              buzzer_on;
    logic [1:0]        fault_kind;
    logic [1:0]        phase;
    logic [DISP_W-1:0] display_value;
    logic              average_done;
  } out_item_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic                is_tick;
    logic                avg_done;
    logic [SAMPLE_W-1:0] avg;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] over_threshold;
    logic [SAMPLE_W-1:0] under_threshold;
    logic [HYST_W-1:0]   hysteresis;
    logic [TICK_W-1:0]   delay_ticks;
    logic [TICK_W-1:0]   buzzer_ticks;
    logic [TICK_W-1:0]   delay_units;
  } cfg_t;

endpackage

[hdl/ouvg_front.sv]
`timescale 1ns / 1ps

module ouvg_front import ouvg_pkg::*; #(
  parameter int unsigned SAMPLES_PER_AVERAGE = SAMPLES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  q_stat_t  q_stat_i,
  output logic     push_o,
  output q_item_t  push_item_o
);

  localparam int unsigned CNT_W   = $clog2(SAMPLES_PER_AVERAGE);
  localparam int unsigned SUM_W   = SAMPLE_W + CNT_W;
  localparam int unsigned SHIFT   = SUM_W + CNT_W;
  localparam int unsigned PROD_W  = SHIFT + SAMPLE_W;
  // Exact floor division for every sum below 2^SUM_W
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + 64'(SAMPLES_PER_AVERAGE) - 64'd1) / 64'(SAMPLES_PER_AVERAGE);
  localparam logic [SUM_W:0]   RECIP    = RECIP_L[SUM_W:0];
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_AVERAGE - 1);

  logic [SUM_W-1:0]  sum_q, sum_d, sum_add;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              accept, last;
  logic [PROD_W-1:0] prod;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i & ~q_stat_i.full;
  assign last       = (cnt_q == CNT_LAST);
  assign sum_add    = sum_q + SUM_W'(in_item_i.sample);
  assign prod       = PROD_W'(sum_add) * PROD_W'(RECIP);

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (accept && in_item_i.cmd == CMD_SAMPLE) begin
      if (last) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_add;
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  assign push_o               = accept;
  assign push_item_o.is_tick  = (in_item_i.cmd == CMD_TICK);
  assign push_item_o.avg_done = (in_item_i.cmd == CMD_SAMPLE) & last;
  assign push_item_o.avg      = prod[SHIFT +: SAMPLE_W];

endmodule

[hdl/ouvg_queue.sv]
`timescale 1ns / 1ps

module ouvg_queue import ouvg_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t push_item_i,
  input  logic    pop_i,
  output q_item_t head_o,
  output q_stat_t stat_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  q_item_t          mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign stat_o.full  = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[hdl/ouvg_back.sv]
`timescale 1ns / 1ps

module ouvg_back import ouvg_pkg::*; #(
  parameter int unsigned TICKS_PER_UNIT = TICKS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  q_item_t   head_i,
  input  q_stat_t   q_stat_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned FRAC_W = (TICKS_PER_UNIT > 1) ? $clog2(TICKS_PER_UNIT) : 1;
  localparam logic [FRAC_W-1:0] FRAC_LAST = FRAC_W'(TICKS_PER_UNIT - 1);
  localparam int unsigned VPROD_W = VOLT_X_W + VOLT_X_W + 1;

  phase_e              phase_q, phase_d;
  fault_e              fault_q, fault_d;
  logic [TICK_W-1:0]   tick_q, tick_d;
  logic [TICK_W-1:0]   unit_q, unit_d;
  logic [FRAC_W-1:0]   frac_q, frac_d;
  logic                relay_q, relay_d;
  logic [DISP_W-1:0]   volt_q, volt_d;
  logic                out_valid_q;
  out_item_t           out_q, result;

  logic                load;
  logic                still_bad;
  logic [VOLT_X_W-1:0] volt_x;
  logic [VPROD_W-1:0]  volt_prod;
  logic [TICK_W-1:0]   units_left;

  assign load  = ~out_valid_q | ~out_stall_i;
  assign pop_o = load & ~q_stat_i.empty;

  // 5*avg, then divide by 11 through the reciprocal
  assign volt_x    = {1'b0, head_i.avg, 2'b00} + VOLT_X_W'(head_i.avg);
  assign volt_prod = VPROD_W'(volt_x) * VPROD_W'(VOLT_RECIP);

  always_comb begin
    if (fault_q == FLT_OVER) begin
      still_bad = ({1'b0, head_i.avg} + 11'(cfg_i.hysteresis)) > {1'b0, cfg_i.over_threshold};
    end else begin
      still_bad = {1'b0, head_i.avg} <= ({1'b0, cfg_i.under_threshold} + 11'(cfg_i.hysteresis));
    end
  end

  // Next state
  always_comb begin
    phase_d = phase_q;
    fault_d = fault_q;
    tick_d  = tick_q;
    unit_d  = unit_q;
    frac_d  = frac_q;
    relay_d = relay_q;
    volt_d  = volt_q;
    if (pop_o) begin
      if (head_i.is_tick) begin
        if (phase_q != PH_NORMAL) begin
          if (tick_q != TICK_MAX) begin
            tick_d = tick_q + 1'b1;
            if (frac_q == FRAC_LAST) begin
              frac_d = '0;
              unit_d = unit_q + 1'b1;
            end else begin
              frac_d = frac_q + 1'b1;
            end
          end
          if ((phase_q == PH_START || phase_q == PH_RECOVER) &&
              tick_d >= cfg_i.delay_ticks) begin
            phase_d = PH_NORMAL;
            fault_d = FLT_NONE;
            relay_d = 1'b1;
          end
        end
      end else if (head_i.avg_done) begin
        volt_d = volt_prod[VOLT_SHIFT +: DISP_W];
        unique case (phase_q)
          PH_START: begin
          end
          PH_NORMAL: begin
            if (head_i.avg > cfg_i.over_threshold) begin
              phase_d = PH_FAULT;
              fault_d = FLT_OVER;
              relay_d = 1'b0;
              tick_d  = '0;
              unit_d  = '0;
              frac_d  = '0;
            end else if (head_i.avg <= cfg_i.under_threshold) begin
              phase_d = PH_FAULT;
              fault_d = FLT_UNDER;
              relay_d = 1'b0;
              tick_d  = '0;
              unit_d  = '0;
              frac_d  = '0;
            end
          end
          PH_FAULT: begin
            if (!still_bad) begin
              phase_d = PH_RECOVER;
              tick_d  = '0;
              unit_d  = '0;
              frac_d  = '0;
            end
          end
          PH_RECOVER: begin
            if (still_bad) begin
              phase_d = PH_FAULT;
              relay_d = 1'b0;
              tick_d  = '0;
              unit_d  = '0;
              frac_d  = '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result fields from the state after the item
  assign units_left = cfg_i.delay_units - unit_d;

  always_comb begin
    result.relay_on     = relay_d;
    result.buzzer_on    = (phase_d == PH_FAULT) && (tick_d < cfg_i.buzzer_ticks);
    result.fault_kind   = fault_d;
    result.phase        = phase_d;
    result.average_done = ~head_i.is_tick & head_i.avg_done;
    if (phase_d == PH_NORMAL || phase_d == PH_FAULT) begin
      result.display_value = volt_d;
    end else if (tick_d >= cfg_i.delay_ticks) begin
      result.display_value = '0;
    end else if (units_left > TICK_W'(DISP_MAX)) begin
      result.display_value = DISP_MAX;
    end else begin
      result.display_value = units_left[DISP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      fault_q     <= FLT_NONE;
      tick_q      <= '0;
      unit_q      <= '0;
      frac_q      <= '0;
      relay_q     <= 1'b0;
      volt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      fault_q <= fault_d;
      tick_q  <= tick_d;
      unit_q  <= unit_d;
      frac_q  <= frac_d;
      relay_q <= relay_d;
      volt_q  <= volt_d;
      if (load) begin
        out_valid_q <= pop_o;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[hdl/over_under_voltage_relay_guard.sv]
`timescale 1ns / 1ps

// Over/under-voltage relay guard.
// Input channel (in_valid_i / in_stall_o / in_item_i): each transfer is either
// an ADC line-voltage sample or a timer tick. Every SAMPLES_PER_AVERAGE samples
// form one average, which drives the protection decision.
// Output channel (out_valid_o / out_stall_i / out_item_o): exactly one result
// per input transfer, in order, showing relay, buzzer, fault, phase, display
// value and whether that sample closed an average.
// Configuration (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i): write
// thresholds, hysteresis, delay and buzzer time while the block is idle; it is
// always ready.
// A result is registered first in the queue and then in the output register
// after its input transfer; throughput is one item per cycle while the receiver
// does not stall, set by the front averager and the back state update, parted
// by a two-entry queue.
// At reset the block enters the start delay with the relay open and the
// registers at their default values; no output is valid.
// When the receiver stalls, the result holds in the output register, the back
// stops draining the queue and in_stall_o rises once the queue fills.

module over_under_voltage_relay_guard import ouvg_pkg::*; #(
  parameter int unsigned SAMPLES_PER_AVERAGE = SAMPLES_DEF,
  parameter int unsigned TICKS_PER_UNIT      = TICKS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Delay in display units, worked out once per write by reciprocal multiply
  localparam int unsigned UNIT_L  = $clog2(TICKS_PER_UNIT);
  localparam int unsigned U_SHIFT = TICK_W + UNIT_L;
  localparam int unsigned U_PROD_W = U_SHIFT + TICK_W;
  localparam longint unsigned U_RECIP_L =
    ((64'd1 << U_SHIFT) + 64'(TICKS_PER_UNIT) - 64'd1) / 64'(TICKS_PER_UNIT);
  localparam logic [TICK_W:0]   U_RECIP         = U_RECIP_L[TICK_W:0];
  localparam logic [TICK_W-1:0] DELAY_UNITS_RST = TICK_W'(DELAY_RST / TICKS_PER_UNIT);

  cfg_t                cfg_q;
  logic [U_PROD_W-1:0] units_prod;

  logic    push;
  q_item_t push_item;
  q_item_t head;
  q_stat_t q_stat;
  logic    pop;

  assign cfg_ready_o = 1'b1;
  assign units_prod  = U_PROD_W'(cfg_data_i) * U_PROD_W'(U_RECIP);

  // Register file: take each write transfer at its index, drop unknown ones
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.over_threshold  <= OVER_RST;
      cfg_q.under_threshold <= UNDER_RST;
      cfg_q.hysteresis      <= HYST_RST;
      cfg_q.delay_ticks     <= DELAY_RST;
      cfg_q.buzzer_ticks    <= BUZZER_RST;
      cfg_q.delay_units     <= DELAY_UNITS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_OVER_THR:  cfg_q.over_threshold  <= cfg_data_i[SAMPLE_W-1:0];
        REG_UNDER_THR: cfg_q.under_threshold <= cfg_data_i[SAMPLE_W-1:0];
        REG_HYST:      cfg_q.hysteresis      <= cfg_data_i[HYST_W-1:0];
        REG_DELAY: begin
          cfg_q.delay_ticks <= cfg_data_i;
          cfg_q.delay_units <= units_prod[U_SHIFT +: TICK_W];
        end
        REG_BUZZER:    cfg_q.buzzer_ticks    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Front: accept and average
  ouvg_front #(
    .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_item_o (push_item)
  );

  // Queue: decouple front stalls from back stalls
  ouvg_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  // Back: protection state machine and output register
  ouvg_back #(
    .TICKS_PER_UNIT(TICKS_PER_UNIT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

[hdl/ouvg_checker.sv]
`timescale 1ns / 1ps

module ouvg_checker import ouvg_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or dropped");

  // Relay closed exactly in normal phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.relay_on == (out_item_o.phase == PH_NORMAL))
    else $error("relay state disagrees with phase");

  // Buzzer only sounds in fault phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.buzzer_on |-> out_item_o.phase == PH_FAULT)
    else $error("buzzer outside fault phase");

  // A fault kind is shown exactly in fault and recovery phases
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.fault_kind == FLT_NONE) ==
      (out_item_o.phase == PH_START || out_item_o.phase == PH_NORMAL))
    else $error("fault kind inconsistent with phase");

endmodule

bind over_under_voltage_relay_guard ouvg_checker u_ouvg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
